### hdl/dkcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkcf_pkg
// Shared types, DES tables and permutation functions for the key filter.
// ----------------------------------------------------------------------------
package dkcf_pkg;

    localparam int KEY_W   = 56;
    localparam int BLK_W   = 64;
    localparam int HALF_W  = 32;
    localparam int OPT_W   = 10;
    localparam int ROUNDS  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int OPT_CBC_BIT  = 8;
    localparam int OPT_FOLD_BIT = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALLOWED_0 = 3'd0,
        CFG_ALLOWED_1 = 3'd1,
        CFG_ALLOWED_2 = 3'd2,
        CFG_ALLOWED_3 = 3'd3,
        CFG_XOR_MASK  = 3'd4,
        CFG_CIPHER_1  = 3'd5,
        CFG_CIPHER_2  = 3'd6,
        CFG_OPTIONS   = 3'd7
    } t_cfg_idx;

    // one transaction moving down the round chain
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  cd;
        logic [HALF_W-1:0] l1;
        logic [HALF_W-1:0] r1;
        logic [HALF_W-1:0] l2;
        logic [HALF_W-1:0] r2;
    } t_lane;

    localparam logic [7:0] IP_TAB [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };
    localparam logic [7:0] FP_TAB [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };
    localparam logic [7:0] E_TAB [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1 };
    localparam logic [7:0] P_TAB [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25 };
    localparam logic [7:0] PC1_TAB [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
        19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };
    localparam logic [7:0] PC2_TAB [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32 };
    localparam logic [1:0] ROT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    localparam logic [3:0] SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

    // table bit 1 is the msb of the input word
    function automatic logic [BLK_W-1:0] des_ip(input logic [BLK_W-1:0] x);
        logic [BLK_W-1:0] y;
        for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(IP_TAB[i])];
        return y;
    endfunction

    function automatic logic [BLK_W-1:0] des_fp(input logic [BLK_W-1:0] x);
        logic [BLK_W-1:0] y;
        for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(FP_TAB[i])];
        return y;
    endfunction

    // 56-bit key to 64-bit key with zero parity, then pc1
    function automatic logic [KEY_W-1:0] key_pc1(input logic [KEY_W-1:0] k);
        logic [BLK_W-1:0] k64;
        logic [KEY_W-1:0] y;
        for (int i = 0; i < 8; i++) k64[63-8*i -: 8] = {k[55-7*i -: 7], 1'b0};
        for (int i = 0; i < 56; i++) y[55-i] = k64[64-int'(PC1_TAB[i])];
        return y;
    endfunction

    function automatic logic [47:0] key_pc2(input logic [KEY_W-1:0] cd);
        logic [47:0] y;
        for (int i = 0; i < 48; i++) y[47-i] = cd[56-int'(PC2_TAB[i])];
        return y;
    endfunction

    function automatic logic [27:0] rotr28(input logic [27:0] x, input int s);
        return (x >> s) | (x << (28 - s));
    endfunction

    function automatic logic [HALF_W-1:0] feistel(input logic [HALF_W-1:0] r,
                                                  input logic [47:0] sub);
        logic [47:0]       e;
        logic [5:0]        six;
        logic [HALF_W-1:0] s;
        logic [HALF_W-1:0] y;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(E_TAB[i])];
        e = e ^ sub;
        for (int i = 0; i < 8; i++) begin
            six = e[47-6*i -: 6];
            s[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) y[31-i] = s[32-int'(P_TAB[i])];
        return y;
    endfunction

endpackage

### hdl/des_key_candidate_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_key_candidate_filter
// Pipelined DES key test: decrypts two blocks per key and checks byte sets.
// ----------------------------------------------------------------------------
// pipeline: the accepting edge loads the first of 16 round cells, and the last
//   round cell feeds the output register
// throughput: one key per cycle, the whole chain advances unless the output
//   register is full and stalled
// reset: synchronous active low, clears stage valids and config registers
// ----------------------------------------------------------------------------
module des_key_candidate_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dkcf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dkcf_pkg::BLK_W-1:0]         i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [dkcf_pkg::KEY_W-1:0]         i_key_candidate,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [dkcf_pkg::KEY_W-1:0]         o_key_tested,
    output logic                               o_first_match_res,
    output logic                               o_full_match
);

    logic [255:0]                   r_allowed;
    logic [dkcf_pkg::BLK_W-1:0]     r_mask;
    logic [dkcf_pkg::BLK_W-1:0]     r_cipher1;
    logic [dkcf_pkg::BLK_W-1:0]     r_cipher2;
    logic [dkcf_pkg::OPT_W-1:0]     r_opt;

    logic                           w_en;
    dkcf_pkg::t_lane                w_entry;
    dkcf_pkg::t_lane                w_lane [dkcf_pkg::ROUNDS+1];
    logic [dkcf_pkg::BLK_W-1:0]     w_ip1;
    logic [dkcf_pkg::BLK_W-1:0]     w_ip2;
    logic [dkcf_pkg::BLK_W-1:0]     w_m1;
    logic [dkcf_pkg::BLK_W-1:0]     w_m2;
    logic                           w_ok1;
    logic                           w_ok2;

    logic                           r_valid;
    logic [dkcf_pkg::KEY_W-1:0]     r_key;
    logic                           r_first;
    logic                           r_full;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allowed <= '0;
            r_mask    <= '0;
            r_cipher1 <= '0;
            r_cipher2 <= '0;
            r_opt     <= '0;
        end else if (i_cfg_we) begin
            unique case (dkcf_pkg::t_cfg_idx'(i_cfg_idx))
                dkcf_pkg::CFG_ALLOWED_0: r_allowed[63:0]    <= i_cfg_data;
                dkcf_pkg::CFG_ALLOWED_1: r_allowed[127:64]  <= i_cfg_data;
                dkcf_pkg::CFG_ALLOWED_2: r_allowed[191:128] <= i_cfg_data;
                dkcf_pkg::CFG_ALLOWED_3: r_allowed[255:192] <= i_cfg_data;
                dkcf_pkg::CFG_XOR_MASK:  r_mask    <= i_cfg_data;
                dkcf_pkg::CFG_CIPHER_1:  r_cipher1 <= i_cfg_data;
                dkcf_pkg::CFG_CIPHER_2:  r_cipher2 <= i_cfg_data;
                dkcf_pkg::CFG_OPTIONS:   r_opt     <= i_cfg_data[dkcf_pkg::OPT_W-1:0];
                default: ;
            endcase
        end
    end

    // chain advances unless the result register holds a stalled transaction
    assign w_en    = !(r_valid && i_stall);
    assign o_stall = !w_en;

    // chain entry: key schedule seed and initial permutation of both blocks
    always_comb begin
        w_ip1         = dkcf_pkg::des_ip(r_cipher1);
        w_ip2         = dkcf_pkg::des_ip(r_cipher2);
        w_entry.valid = i_valid;
        w_entry.key   = i_key_candidate;
        w_entry.cd    = dkcf_pkg::key_pc1(i_key_candidate);
        w_entry.l1    = w_ip1[63:32];
        w_entry.r1    = w_ip1[31:0];
        w_entry.l2    = w_ip2[63:32];
        w_entry.r2    = w_ip2[31:0];
    end

    assign w_lane[0] = w_entry;

    // sixteen round cells
    for (genvar g = 0; g < dkcf_pkg::ROUNDS; g++) begin : g_cell
        dkcf_round_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_lane  (w_lane[g]),
            .o_lane  (w_lane[g+1])
        );
    end

    // final permutation, fold, mask on block 1 and cbc on block 2
    always_comb begin
        w_m1 = dkcf_pkg::des_fp({w_lane[dkcf_pkg::ROUNDS].r1, w_lane[dkcf_pkg::ROUNDS].l1});
        w_m2 = dkcf_pkg::des_fp({w_lane[dkcf_pkg::ROUNDS].r2, w_lane[dkcf_pkg::ROUNDS].l2});
        if (r_opt[dkcf_pkg::OPT_FOLD_BIT]) begin
            w_m1 = w_m1 ^ {w_m1[31:0], 32'd0};
            w_m2 = w_m2 ^ {w_m2[31:0], 32'd0};
        end
        w_m1 = w_m1 ^ r_mask;
        if (r_opt[dkcf_pkg::OPT_CBC_BIT]) begin
            w_m2 = w_m2 ^ r_cipher1;
        end
    end

    // byte set test, byte 0 is the most significant
    always_comb begin
        w_ok1 = 1'b1;
        w_ok2 = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (!r_opt[7-i]) begin
                if (!r_allowed[w_m1[63-8*i -: 8]]) w_ok1 = 1'b0;
                if (!r_allowed[w_m2[63-8*i -: 8]]) w_ok2 = 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_lane[dkcf_pkg::ROUNDS].valid;
        end
        if (w_en) begin
            r_key   <= w_lane[dkcf_pkg::ROUNDS].key;
            r_first <= w_ok1;
            r_full  <= w_ok1 && w_ok2;
        end
    end

    assign o_valid           = r_valid;
    assign o_key_tested      = r_key;
    assign o_first_match_res = r_first;
    assign o_full_match      = r_full;

    // checks
    a_full_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_full_match || o_first_match_res))
        else $error("full match without first match");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while result register free");
    a_chain_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_lane[dkcf_pkg::ROUNDS].valid) |=> o_valid)
        else $error("transaction lost at chain end");
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

### hdl/dkcf_round_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkcf_round_cell
// One DES decryption round for both cipher blocks plus its key schedule step.
// ----------------------------------------------------------------------------
module dkcf_round_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  dkcf_pkg::t_lane i_lane,
    output dkcf_pkg::t_lane o_lane
);

    localparam int ROT = int'(dkcf_pkg::ROT_TAB[dkcf_pkg::ROUNDS-1-CELL_IDX]);

    dkcf_pkg::t_lane r_lane;
    dkcf_pkg::t_lane n_lane;
    logic [47:0]     w_sub;

    // round function on both blocks, then shift the schedule for the next cell
    always_comb begin
        w_sub        = dkcf_pkg::key_pc2(i_lane.cd);
        n_lane       = i_lane;
        n_lane.l1    = i_lane.r1;
        n_lane.r1    = i_lane.l1 ^ dkcf_pkg::feistel(i_lane.r1, w_sub);
        n_lane.l2    = i_lane.r2;
        n_lane.r2    = i_lane.l2 ^ dkcf_pkg::feistel(i_lane.r2, w_sub);
        n_lane.cd    = {dkcf_pkg::rotr28(i_lane.cd[55:28], ROT),
                        dkcf_pkg::rotr28(i_lane.cd[27:0], ROT)};
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane.valid <= n_lane.valid;
        end
        if (i_en) begin
            r_lane.key <= n_lane.key;
            r_lane.cd  <= n_lane.cd;
            r_lane.l1  <= n_lane.l1;
            r_lane.r1  <= n_lane.r1;
            r_lane.l2  <= n_lane.l2;
            r_lane.r2  <= n_lane.r2;
        end
    end

    assign o_lane = r_lane;

endmodule
